[sv/lnwd_pkg.sv]
// shared types and constants of the lcd nibble writer with decimal output
package lnwd_pkg;

   typedef enum logic [1:0] {
      OP_CMD  = 2'd0,
      OP_DATA = 2'd1,
      OP_NUM  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        is_num;
      logic        rs;
      logic [7:0]  byte_val;
      logic [16:0] num;
      logic [2:0]  count;
   } job_type;

   localparam logic [2:0]  MIN_DIGITS   = 3'd2;
   localparam logic [3:0]  ASCII_HIGH   = 4'h3;
   localparam logic [15:0] RECIP_TEN    = 16'd52429;
   localparam int          RECIP_SHIFT  = 19;
   localparam logic        RS_DATA      = 1'b1;

endpackage

[sv/lnwd_front.sv]
// front end: accepts requests, drops unused op codes, clamps the digit count
module lnwd_front #(
   parameter int MAX_DIGITS = 5
) (
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_op,
   input  logic [7:0]       in_byte,
   input  logic [16:0]      in_num,
   input  logic [2:0]       in_count,
   output logic             push,
   output lnwd_pkg::job_type job,
   input  logic             q_ready
);
   import lnwd_pkg::*;

   localparam logic [2:0] CNT_MAX = (MAX_DIGITS > 7) ? 3'd7 : 3'(MAX_DIGITS);

   logic [2:0] count_c;
   logic       known_op;

   always_comb begin
      count_c = in_count;
      if (count_c < MIN_DIGITS) begin
         count_c = MIN_DIGITS;
      end
      if (count_c > CNT_MAX) begin
         count_c = CNT_MAX;
      end
   end

   assign known_op = (in_op == OP_CMD) || (in_op == OP_DATA) || (in_op == OP_NUM);
   assign in_ready = q_ready;
   assign push     = in_valid && q_ready && known_op;

   always_comb begin
      job          = '0;
      job.is_num   = (in_op == OP_NUM);
      job.rs       = (in_op == OP_DATA) ? 1'b1 : 1'b0;
      job.byte_val = in_byte;
      job.num      = in_num;
      job.count    = count_c;
   end

endmodule

[sv/lnwd_queue.sv]
// two-entry queue between front end and back end
module lnwd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lnwd_pkg::job_type wr_job,
   output logic             wr_ready,
   input  logic             pop,
   output lnwd_pkg::job_type rd_job,
   output logic             rd_valid
);
   import lnwd_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_job   = mem_ff[rd_ptr_ff];
   assign do_push  = push && wr_ready;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

[sv/lnwd_back.sv]
// back end: serial decimal conversion and nibble emission with output register
module lnwd_back #(
   parameter int MAX_DIGITS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  lnwd_pkg::job_type q_job,
   output logic             q_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_rs,
   output logic [3:0]       out_nibble,
   output logic             out_last
);
   import lnwd_pkg::*;

   localparam int DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW = (DW > 3) ? DW : 3;

   state_type   state_ff, state_in;
   logic        is_num_ff, is_num_in;
   logic        rs_ff, rs_in;
   logic [7:0]  byte_ff, byte_in;
   logic [16:0] val_ff, val_in;
   logic [2:0]  count_ff, count_in;
   logic [DW-1:0] dig_ff, dig_in;
   logic        half_ff, half_in;
   logic [3:0]  digit_ff [MAX_DIGITS];

   logic        out_valid_ff, out_valid_in;
   logic        out_rs_ff, out_rs_in;
   logic [3:0]  out_nib_ff, out_nib_in;
   logic        out_last_ff, out_last_in;

   logic [32:0] prod;
   logic [16:0] quot;
   logic [16:0] quot_x10;
   logic [3:0]  rem;
   logic        dig_wr;
   logic        out_free;
   logic        emit;
   logic        top_dig;
   logic        bottom_dig;
   logic        nib_last;
   logic [3:0]  nib_val;
   logic        nib_rs;

   // divide by ten through the reciprocal, exact for 17-bit values
   assign prod     = 33'(val_ff) * 33'(RECIP_TEN);
   assign quot     = 17'(prod >> RECIP_SHIFT);
   assign quot_x10 = 17'({quot, 3'b000}) + 17'({quot, 1'b0});
   assign rem      = 4'(val_ff - quot_x10);

   assign top_dig    = (CW'(dig_ff) == CW'(count_ff - 3'd1));
   assign bottom_dig = (dig_ff == '0);
   assign out_free   = !out_valid_ff || out_ready;

   always_comb begin
      if (is_num_ff) begin
         nib_rs   = RS_DATA;
         nib_val  = half_ff ? digit_ff[dig_ff] : ASCII_HIGH;
         nib_last = half_ff && bottom_dig;
      end else begin
         nib_rs   = rs_ff;
         nib_val  = half_ff ? byte_ff[3:0] : byte_ff[7:4];
         nib_last = half_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      is_num_in = is_num_ff;
      rs_in     = rs_ff;
      byte_in   = byte_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      dig_in    = dig_ff;
      half_in   = half_ff;
      q_pop     = 1'b0;
      dig_wr    = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               is_num_in = q_job.is_num;
               rs_in     = q_job.rs;
               byte_in   = q_job.byte_val;
               val_in    = q_job.num;
               count_in  = q_job.count;
               dig_in    = '0;
               half_in   = 1'b0;
               state_in  = q_job.is_num ? ST_CONV : ST_EMIT;
            end
         end
         ST_CONV: begin
            dig_wr = 1'b1;
            val_in = quot;
            if (top_dig) begin
               half_in  = 1'b0;
               state_in = ST_EMIT;
            end else begin
               dig_in = dig_ff + DW'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit    = 1'b1;
               half_in = ~half_ff;
               if (nib_last) begin
                  state_in = ST_IDLE;
               end else if (is_num_ff && half_ff) begin
                  dig_in = dig_ff - DW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_rs_in   = out_rs_ff;
      out_nib_in  = out_nib_ff;
      out_last_in = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_rs_in    = nib_rs;
         out_nib_in   = nib_val;
         out_last_in  = nib_last;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_num_ff   <= is_num_in;
      rs_ff       <= rs_in;
      byte_ff     <= byte_in;
      val_ff      <= val_in;
      count_ff    <= count_in;
      dig_ff      <= dig_in;
      half_ff     <= half_in;
      out_rs_ff   <= out_rs_in;
      out_nib_ff  <= out_nib_in;
      out_last_ff <= out_last_in;
      if (dig_wr) begin
         digit_ff[dig_ff] <= rem;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_rs     = out_rs_ff;
   assign out_nibble = out_nib_ff;
   assign out_last   = out_last_ff;

endmodule

[sv/lcd_nibble_writer_decimal.sv]
// top level of the lcd nibble writer with decimal number output
// usage:
//   req channel takes one request per handshake: tuser carries the op code
//   (command byte, data byte or decimal number), tdata the byte, the number
//   and the digit count. op code 3 is accepted and dropped.
//   rsp channel gives one nibble write per handshake, tlast on the final one
//   of a request, tuser the register-select bit.
//   a byte request yields two nibbles, high first; a number request yields
//   two nibbles per digit (0x3 then the digit), most significant digit first.
// flow:
//   a request reaches the back end through a two-entry queue; a byte request
//   is then loaded and emitted as two nibbles, a number request is loaded,
//   passes through the divide-by-ten loop, which yields its digits least
//   significant first, and is then emitted as two nibbles per digit.
//   the first nibble of a request reaches rsp through the output register once
//   the back end has loaded a byte request or ended a number request's digit loop.
// reset clears the queue, the back-end state and the output valid flag.
// a stalled rsp side holds the output register; the queue keeps taking
// requests until its two entries are full.
module lcd_nibble_writer_decimal #(
   parameter int MAX_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // byte_value, number_value, digit_count, zero pad
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // nibble, zero pad
   output logic        rsp_tuser,  // reg_select
   output logic        rsp_tlast
);
   import lnwd_pkg::*;

   logic    push;
   job_type front_job;
   logic    q_ready;
   job_type q_job;
   logic    q_valid;
   logic    q_pop;
   logic [3:0] nibble;

   lnwd_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (req_tuser),
      .in_byte  (req_tdata[7:0]),
      .in_num   (req_tdata[24:8]),
      .in_count (req_tdata[27:25]),
      .push     (push),
      .job      (front_job),
      .q_ready  (q_ready)
   );

   lnwd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_job   (front_job),
      .wr_ready (q_ready),
      .pop      (q_pop),
      .rd_job   (q_job),
      .rd_valid (q_valid)
   );

   lnwd_back #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rs     (rsp_tuser),
      .out_nibble (nibble),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, nibble};

endmodule
